/* rtl/msm_pkg.sv */
// Package for the multi-voice sample mixer: codes, widths, shared types and
// the sample scaling function. No dependencies.
package msm_pkg;

	localparam int NUM_VOICES_DEF    = 8;
	localparam int SAMPLE_FRAMES_DEF = 65536;

	localparam logic [17:0] OUT_RATE_RST = 18'd48000;

	// Action codes carried in the input tuser.
	localparam logic [2:0] ACT_LOAD    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_TICK    = 3'd2;
	localparam logic [2:0] ACT_VOLUME  = 3'd3;
	localparam logic [2:0] ACT_RELEASE = 3'd4;

	// Divider: 50-bit dividend (offset times rate), 25-bit divisor.
	localparam int DIV_NW = 50;
	localparam int DIV_DW = 25;
	localparam int DIV_CW = 6;

	localparam logic [DIV_CW-1:0] DIV_STEPS_IDX = 6'd50;
	localparam logic [DIV_CW-1:0] DIV_STEPS_MOD = 6'd17;

	// Shared multiplier: 33 by 19 signed.
	localparam int MUL_AW = 33;
	localparam int MUL_BW = 19;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	typedef struct packed {
		logic              start;
		logic [DIV_CW-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// Product divided by 256 toward zero, then saturated to 16 bits.
	function automatic logic [15:0] scale_sample(input logic signed [MUL_PW-1:0] p);
		logic signed [MUL_PW-1:0] q;
		begin
			q = p >>> 8;
			if (p[MUL_PW-1] && (p[7:0] != 8'd0)) begin
				q = q + MUL_PW'(1);
			end
			if (q > MUL_PW'(32767)) begin
				scale_sample = 16'h7fff;
			end else if (q < -MUL_PW'(32768)) begin
				scale_sample = 16'h8000;
			end else begin
				scale_sample = q[15:0];
			end
		end
	endfunction

endpackage

/* rtl/msm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/msm_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on msm_pkg.
module msm_mul (
	input  logic                                clk,
	input  logic signed [msm_pkg::MUL_AW-1:0]   a,
	input  logic signed [msm_pkg::MUL_BW-1:0]   b,
	output logic signed [msm_pkg::MUL_PW-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

/* rtl/msm_div.sv */
// Restoring divider, one quotient bit per cycle, shared for the frame index
// and for address wrapping. Depends on msm_pkg.
module msm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msm_pkg::div_ctl_t                ctl,
	input  logic [msm_pkg::DIV_NW-1:0]       dividend,
	input  logic [msm_pkg::DIV_DW-1:0]       divisor,
	output msm_pkg::div_sts_t                sts,
	output logic [msm_pkg::DIV_NW-1:0]       quotient,
	output logic [msm_pkg::DIV_DW-1:0]       remainder
);

	logic                          busy_q;
	logic [msm_pkg::DIV_CW-1:0]    cnt_q;
	logic [msm_pkg::DIV_NW-1:0]    q_q;
	logic [msm_pkg::DIV_DW-1:0]    r_q;
	logic [msm_pkg::DIV_DW-1:0]    d_q;
	logic [msm_pkg::DIV_DW:0]      trial;
	logic                          fits;

	assign trial = {r_q, q_q[msm_pkg::DIV_NW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The caller aligns a short dividend to the top bits and runs fewer steps.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			q_q <= {q_q[msm_pkg::DIV_NW-2:0], fits};
			r_q <= fits ? msm_pkg::DIV_DW'(trial - {1'b0, d_q}) : trial[msm_pkg::DIV_DW-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = busy_q && (cnt_q == '0);
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

/* rtl/multi_voice_sample_mixer_unit.sv */
// Top level of the multi-voice sample mixer: sequencer, voice state and
// sample memory. Depends on msm_pkg, msm_ram, msm_mul and msm_div.
//
// Channel   Direction  Ports                       Payload
// s_axis    in         tvalid tready tdata tuser   action in tuser, item in tdata
// m_axis    out        tvalid tready tdata         one mixed frame per tick
// cfg       in         cfg_we cfg_wdata            out_rate
//
// Start, set volume and release are taken in the accepting cycle, as is a
// load when SAMPLE_FRAMES is a power of two; otherwise a load passes S_LDMOD,
// S_LDWT and S_LDWR. A tick skips silent voices in S_TREAD; a voice that ends
// passes S_TREAD, S_TMUL, S_TDIV, S_TDWT, S_TCHK, a playing voice then S_TMWT
// (no power-of-two memory), S_TMEM to S_TACC; S_FIN hands over the frame.
// Reset clears voice flags and the handshakes and sets out_rate to 48000;
// memories are not cleared. A frame waits in the output register; input is
// taken meanwhile unless a further frame waits in S_FIN for it to go.
module multi_voice_sample_mixer_unit #(
	parameter int NUM_VOICES    = msm_pkg::NUM_VOICES_DEF,
	parameter int SAMPLE_FRAMES = msm_pkg::SAMPLE_FRAMES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// voice, address, left_in, right_in, length, sound_rate, volume,
	// start_frame, auto_free (from bit 0 up)
	input  logic [135:0]  s_axis_tdata,
	// action
	input  logic [2:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// left_out, right_out, clip, done_mask (from bit 0 up)
	output logic [47:0]   m_axis_tdata,
	input  logic          cfg_we,
	input  logic [17:0]   cfg_wdata
);

	localparam int  VW      = NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1;
	localparam int  AW      = SAMPLE_FRAMES > 1 ? $clog2(SAMPLE_FRAMES) : 1;
	localparam bit  SF_POW2 = (SAMPLE_FRAMES & (SAMPLE_FRAMES - 1)) == 0;

	typedef enum logic [3:0] {
		S_IDLE, S_LDMOD, S_LDWT, S_LDWR, S_TREAD, S_TMUL, S_TDIV, S_TDWT,
		S_TCHK, S_TMWT, S_TMEM, S_TSCL, S_TSCR, S_TACC, S_FIN
	} state_t;

	state_t state_q;

	// Input fields.
	logic [2:0]  in_voice;
	logic [15:0] in_addr;
	logic [15:0] in_left;
	logic [15:0] in_right;
	logic [16:0] in_length;
	logic [17:0] in_rate;
	logic [11:0] in_volume;
	logic [31:0] in_start;
	logic        in_auto;

	assign in_voice  = s_axis_tdata[2:0];
	assign in_addr   = s_axis_tdata[18:3];
	assign in_left   = s_axis_tdata[34:19];
	assign in_right  = s_axis_tdata[50:35];
	assign in_length = s_axis_tdata[67:51];
	assign in_rate   = s_axis_tdata[85:68];
	assign in_volume = s_axis_tdata[97:86];
	assign in_start  = s_axis_tdata[129:98];
	assign in_auto   = s_axis_tdata[130];

	logic          accept;
	logic [6:0]    vin_ext;
	logic [VW-1:0] vin_ix;
	logic          vok;
	logic [24:0]   in_addr_wide;

	assign accept       = s_axis_tvalid && s_axis_tready;
	assign vin_ext      = {4'b0, in_voice};
	assign vin_ix       = vin_ext[VW-1:0];
	assign vok          = vin_ext < 7'(NUM_VOICES);
	assign in_addr_wide = {9'b0, in_addr};
	assign s_axis_tready = state_q == S_IDLE;

	logic                      acc_start;
	logic                      acc_load;
	logic                      acc_volume;
	logic                      acc_release;
	logic                      acc_tick;

	assign acc_start   = accept && (s_axis_tuser == msm_pkg::ACT_START) && vok;
	assign acc_load    = accept && (s_axis_tuser == msm_pkg::ACT_LOAD);
	assign acc_volume  = accept && (s_axis_tuser == msm_pkg::ACT_VOLUME) && vok;
	assign acc_release = accept && (s_axis_tuser == msm_pkg::ACT_RELEASE) && vok;
	assign acc_tick    = accept && (s_axis_tuser == msm_pkg::ACT_TICK);

	// Registers.
	logic [17:0]           out_rate_q;
	logic [NUM_VOICES-1:0] active_q;
	logic [NUM_VOICES-1:0] done_q;
	logic [VW-1:0]         vcnt_q;
	logic [15:0]           ld_addr_q;
	logic [15:0]           ld_left_q;
	logic [15:0]           ld_right_q;
	logic [AW-1:0]         mem_addr_q;
	logic [15:0]           acc_l_q;
	logic [15:0]           acc_r_q;
	logic                  clip_q;
	logic [15:0]           sl_q;

	// Voice memories, read at the scan counter.
	logic [51:0] st_rd;
	logic [11:0] gain_rd;
	logic [31:0] off_rd;
	logic [15:0] base_rd;
	logic [16:0] len_rd;
	logic [17:0] rate_rd;
	logic        auto_rd;

	assign base_rd = st_rd[15:0];
	assign len_rd  = st_rd[32:16];
	assign rate_rd = st_rd[50:33];
	assign auto_rd = st_rd[51];

	logic          off_we;
	logic [VW-1:0] off_waddr;
	logic [31:0]   off_wdata;

	msm_ram #(.WIDTH(52), .DEPTH(NUM_VOICES)) u_static_ram (
		.clk(clk), .we(acc_start), .waddr(vin_ix),
		.wdata({in_auto, in_rate, in_length, in_addr}),
		.raddr(vcnt_q), .rdata(st_rd)
	);

	msm_ram #(.WIDTH(12), .DEPTH(NUM_VOICES)) u_gain_ram (
		.clk(clk), .we(acc_start || acc_volume), .waddr(vin_ix), .wdata(in_volume),
		.raddr(vcnt_q), .rdata(gain_rd)
	);

	msm_ram #(.WIDTH(32), .DEPTH(NUM_VOICES)) u_offset_ram (
		.clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
		.raddr(vcnt_q), .rdata(off_rd)
	);

	// Sample memory: left in the low half, right in the high half.
	logic          smp_we;
	logic [AW-1:0] smp_waddr;
	logic [31:0]   smp_wdata;
	logic [31:0]   smp_rd;

	msm_ram #(.WIDTH(32), .DEPTH(SAMPLE_FRAMES)) u_sample_ram (
		.clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
		.raddr(mem_addr_q), .rdata(smp_rd)
	);

	// Shared multiplier and divider.
	logic signed [msm_pkg::MUL_AW-1:0] mul_a;
	logic signed [msm_pkg::MUL_BW-1:0] mul_b;
	logic signed [msm_pkg::MUL_PW-1:0] mul_p;

	msm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	msm_pkg::div_ctl_t             div_ctl;
	msm_pkg::div_sts_t             div_sts;
	logic [msm_pkg::DIV_NW-1:0]    div_num;
	logic [msm_pkg::DIV_DW-1:0]    div_den;
	logic [msm_pkg::DIV_NW-1:0]    div_quo;
	logic [msm_pkg::DIV_DW-1:0]    div_rem;

	msm_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .dividend(div_num),
		.divisor(div_den), .sts(div_sts), .quotient(div_quo), .remainder(div_rem)
	);

	// Voice step decisions.
	logic        voice_live;
	logic        last_voice;
	logic        idx_end;
	logic [16:0] play_sum;
	logic [24:0] play_wide;
	logic [16:0] mod_val;
	logic [17:0] rate_div;
	logic [15:0] sr_now;
	logic [15:0] acc_l_n;
	logic [15:0] acc_r_n;
	logic        clip_n;
	logic [7:0]  done_mask;

	assign voice_live = active_q[vcnt_q] && !done_q[vcnt_q];
	assign last_voice = vcnt_q == VW'(NUM_VOICES - 1);
	assign idx_end    = div_quo >= msm_pkg::DIV_NW'(len_rd);
	assign play_sum   = {1'b0, base_rd} + {1'b0, div_quo[15:0]};
	assign play_wide  = {8'b0, play_sum};
	assign mod_val    = (state_q == S_LDMOD) ? {1'b0, ld_addr_q} : play_sum;
	assign rate_div   = (out_rate_q == '0) ? 18'd1 : out_rate_q;

	assign sr_now  = msm_pkg::scale_sample(mul_p);
	assign acc_l_n = acc_l_q + sl_q;
	assign acc_r_n = acc_r_q + sr_now;
	assign clip_n  = (acc_l_n == 16'h7fff) || (acc_l_n == 16'h8000) ||
	                 (acc_r_n == 16'h7fff) || (acc_r_n == 16'h8000);

	always_comb begin
		div_ctl.start = (state_q == S_TDIV) || (state_q == S_LDMOD) ||
		                ((state_q == S_TCHK) && !idx_end && !SF_POW2);
		div_ctl.steps = (state_q == S_TDIV) ? msm_pkg::DIV_STEPS_IDX
		                                    : msm_pkg::DIV_STEPS_MOD;
		div_num       = (state_q == S_TDIV) ? mul_p[msm_pkg::DIV_NW-1:0]
		                                    : {mod_val, 33'b0};
		div_den       = (state_q == S_TDIV) ? {7'b0, rate_div}
		                                    : msm_pkg::DIV_DW'(SAMPLE_FRAMES);
	end

	always_comb begin
		case (state_q)
			S_TMUL: begin
				mul_a = {1'b0, off_rd};
				mul_b = {1'b0, rate_rd};
			end
			S_TSCR: begin
				mul_a = {{17{smp_rd[31]}}, smp_rd[31:16]};
				mul_b = {7'b0, gain_rd};
			end
			default: begin
				mul_a = {{17{smp_rd[15]}}, smp_rd[15:0]};
				mul_b = {7'b0, gain_rd};
			end
		endcase
	end

	always_comb begin
		off_we    = acc_start || ((state_q == S_TCHK) && idx_end) || (state_q == S_TACC);
		off_waddr = (state_q == S_IDLE) ? vin_ix : vcnt_q;
		off_wdata = (state_q == S_IDLE) ? in_start : off_rd + 32'd1;
		smp_we    = (acc_load && SF_POW2) || (state_q == S_LDWR);
		smp_waddr = (state_q == S_LDWR) ? mem_addr_q : in_addr_wide[AW-1:0];
		smp_wdata = (state_q == S_LDWR) ? {ld_right_q, ld_left_q} : {in_right, in_left};
	end

	for (genvar g = 0; g < 8; g++) begin : g_mask
		if (g < NUM_VOICES) begin : g_on
			assign done_mask[g] = active_q[g] && done_q[g];
		end else begin : g_off
			assign done_mask[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_rate_q    <= msm_pkg::OUT_RATE_RST;
			active_q      <= '0;
			done_q        <= '0;
			vcnt_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				out_rate_q <= cfg_wdata;
			end
			// A frame that completes in the same cycle is handled by the final state.
			if (m_axis_tvalid && m_axis_tready && (state_q != S_FIN)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_start) begin
						active_q[vin_ix] <= 1'b1;
						done_q[vin_ix]   <= 1'b0;
					end
					if (acc_release) begin
						active_q[vin_ix] <= 1'b0;
						done_q[vin_ix]   <= 1'b0;
					end
					if (acc_load && !SF_POW2) begin
						ld_addr_q  <= in_addr;
						ld_left_q  <= in_left;
						ld_right_q <= in_right;
						state_q    <= S_LDMOD;
					end
					if (acc_tick) begin
						vcnt_q  <= '0;
						acc_l_q <= '0;
						acc_r_q <= '0;
						clip_q  <= 1'b0;
						state_q <= S_TREAD;
					end
				end
				S_LDMOD: state_q <= S_LDWT;
				S_LDWT: begin
					if (div_sts.done) begin
						mem_addr_q <= div_rem[AW-1:0];
						state_q    <= S_LDWR;
					end
				end
				S_LDWR: state_q <= S_IDLE;
				S_TREAD: begin
					if (voice_live) begin
						state_q <= S_TMUL;
					end else if (last_voice) begin
						state_q <= S_FIN;
					end else begin
						vcnt_q <= vcnt_q + 1'b1;
					end
				end
				S_TMUL: state_q <= S_TDIV;
				S_TDIV: state_q <= S_TDWT;
				S_TDWT: begin
					if (div_sts.done) begin
						state_q <= S_TCHK;
					end
				end
				S_TCHK: begin
					if (idx_end) begin
						if (auto_rd) begin
							active_q[vcnt_q] <= 1'b0;
						end else begin
							done_q[vcnt_q] <= 1'b1;
						end
						if (last_voice) begin
							state_q <= S_FIN;
						end else begin
							vcnt_q  <= vcnt_q + 1'b1;
							state_q <= S_TREAD;
						end
					end else if (SF_POW2) begin
						mem_addr_q <= play_wide[AW-1:0];
						state_q    <= S_TMEM;
					end else begin
						state_q <= S_TMWT;
					end
				end
				S_TMWT: begin
					if (div_sts.done) begin
						mem_addr_q <= div_rem[AW-1:0];
						state_q    <= S_TMEM;
					end
				end
				S_TMEM: state_q <= S_TSCL;
				S_TSCL: state_q <= S_TSCR;
				S_TSCR: begin
					sl_q    <= msm_pkg::scale_sample(mul_p);
					state_q <= S_TACC;
				end
				S_TACC: begin
					acc_l_q <= acc_l_n;
					acc_r_q <= acc_r_n;
					clip_q  <= clip_q || clip_n;
					if (last_voice) begin
						state_q <= S_FIN;
					end else begin
						vcnt_q  <= vcnt_q + 1'b1;
						state_q <= S_TREAD;
					end
				end
				S_FIN: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {7'b0, done_mask, clip_q, acc_r_q, acc_l_q};
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/msm_chk.sv */
// Port-level checker for the multi-voice sample mixer, bound to the top level.
// Depends on msm_pkg.
module msm_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [2:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [47:0]  m_axis_tdata
);

	// A frame that waits is held until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output frame dropped or changed while stalled");

	// Only a tick makes a frame.
	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser != msm_pkg::ACT_TICK) &&
		!m_axis_tvalid |=> !m_axis_tvalid)
		else $error("frame produced by an action other than tick");

	// A tick closes the input once it is taken.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == msm_pkg::ACT_TICK)
		|=> !s_axis_tready)
		else $error("input taken during a tick");

	// A new frame appears only while the input side is closed.
	a_frame_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("frame appeared without a tick in progress");

endmodule

bind multi_voice_sample_mixer_unit msm_chk u_msm_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
